FILE: hw/rtl/spims_pkg.sv
// ----------------------------------------------------------------------------
// SPI master bit sequencer package
// Shared types and constants: command codes, one-hot phases, pin positions,
// item, state and result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package spims_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 6;

  // pin positions in the pin level vector
  localparam int SEL_BIT = 2;
  localparam int CLK_BIT = 1;
  localparam int DAT_BIT = 0;

  localparam logic [2:0] PINS_RESET = 3'b100;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_START  = 11'b000_0000_0010,
    PH_CSLOW  = 11'b000_0000_0100,
    PH_WCLKDN = 11'b000_0000_1000,
    PH_WDATA  = 11'b000_0001_0000,
    PH_WCLKUP = 11'b000_0010_0000,
    PH_CSUP   = 11'b000_0100_0000,
    PH_CLKDN  = 11'b000_1000_0000,
    PH_STOP   = 11'b001_0000_0000,
    PH_RCLKDN = 11'b010_0000_0000,
    PH_RCLKUP = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [WORD_W-1:0]   write_word;
    logic [COUNT_W-1:0]  bit_count;
    logic                serial_in;
  } item_t;

  typedef struct packed {
    phase_t              phase;
    logic [2:0]          pins;
    logic [WORD_W-1:0]   shift_word;
    logic                is_read;
  } ctl_t;

  typedef struct packed {
    logic                select_line;
    logic                clock_line;
    logic                data_out_line;
    logic                busy_res;
    logic [WORD_W-1:0]   read_word;
    logic                done_res;
    logic                rejected;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spi_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// SPI master bit sequencer
// Item register, combinational phase step and result register around the
// select/clock/data pin state.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes from the item register to the result
// register, where out_valid rises; a stalled result register holds it back.
// Throughput: one item per cycle while out_ready does not stall the result
// register; the phase state updates as the item leaves the item register.
// Reset (rst_n low, synchronous): select high, clock and data low, idle,
// conversion mode off, both pipeline registers empty.
`default_nettype none

module spi_master_bit_sequencer
  import spims_pkg::*;
#(
  parameter int MAX_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [WORD_W-1:0]   in_write_word,
  input  wire logic [COUNT_W-1:0]  in_bit_count,
  input  wire logic                in_serial_in,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_select_line,
  output logic                     out_clock_line,
  output logic                     out_data_out_line,
  output logic                     out_busy_res,
  output logic [WORD_W-1:0]        out_read_word,
  output logic                     out_done_res,
  output logic                     out_rejected
);

  localparam int BW = $clog2(MAX_BITS + 1);

  logic          conv_r;
  logic          in_v_r;
  item_t         item_r;
  ctl_t          ctl_r;
  ctl_t          ctl_nxt;
  logic [BW-1:0] bits_left_r;
  logic [BW-1:0] bits_left_nxt;
  logic          out_v_r;
  res_t          res_r;
  res_t          res_nxt;
  logic          advance;

  assign cfg_ready = 1'b1;
  assign advance   = ~out_v_r | out_ready;
  assign in_ready  = ~in_v_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      conv_r <= cfg_data;
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.cmd        <= cmd_t'(in_cmd);
      item_r.write_word <= in_write_word;
      item_r.bit_count  <= in_bit_count;
      item_r.serial_in  <= in_serial_in;
    end
  end

  spims_step #(
    .MAX_BITS (MAX_BITS)
  ) u_step (
    .item          (item_r),
    .ctl           (ctl_r),
    .bits_left     (bits_left_r),
    .conv_mode     (conv_r),
    .ctl_nxt       (ctl_nxt),
    .bits_left_nxt (bits_left_nxt),
    .res           (res_nxt)
  );

  // phase state, advance only as an item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase      <= PH_IDLE;
      ctl_r.pins       <= PINS_RESET;
      ctl_r.shift_word <= '0;
      ctl_r.is_read    <= 1'b0;
      bits_left_r      <= '0;
    end else if (in_v_r && advance) begin
      ctl_r       <= ctl_nxt;
      bits_left_r <= bits_left_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_select_line   = res_r.select_line;
  assign out_clock_line    = res_r.clock_line;
  assign out_data_out_line = res_r.data_out_line;
  assign out_busy_res      = res_r.busy_res;
  assign out_read_word     = res_r.read_word;
  assign out_done_res      = res_r.done_res;
  assign out_rejected      = res_r.rejected;

endmodule

`default_nettype wire

FILE: hw/rtl/spims_step.sv
// ----------------------------------------------------------------------------
// SPI master phase step
// Next-state and result logic for one item: start commands load the word and
// bit count (rejected if not idle); ticks advance the phase, no-ops hold it.
// ----------------------------------------------------------------------------
`default_nettype none

module spims_step
  import spims_pkg::*;
#(
  parameter int MAX_BITS = 32
) (
  input  item_t                           item,
  input  ctl_t                            ctl,
  input  logic [$clog2(MAX_BITS+1)-1:0]   bits_left,
  input  logic                            conv_mode,
  output ctl_t                            ctl_nxt,
  output logic [$clog2(MAX_BITS+1)-1:0]   bits_left_nxt,
  output res_t                            res
);

  localparam int BW = $clog2(MAX_BITS + 1);

  logic [BW-1:0]     bl_dec;
  logic [BW-1:0]     bl_load;
  logic [6:0]        idx7;
  logic              tx_bit;
  logic [2:0]        p;
  logic              done;
  logic              rej;

  assign bl_dec  = (bits_left != '0) ? bits_left - BW'(1) : '0;
  assign bl_load = (int'(item.bit_count) > MAX_BITS) ? BW'(MAX_BITS) : BW'(item.bit_count);
  assign idx7    = 7'(bl_dec);
  assign tx_bit  = (idx7 < 7'd32) ? ctl.shift_word[idx7[4:0]] : 1'b0;

  always_comb begin
    ctl_nxt       = ctl;
    bits_left_nxt = bits_left;
    p             = ctl.pins;
    done          = 1'b0;
    rej           = 1'b0;
    unique case (item.cmd)
      CMD_WRITE, CMD_READ: begin
        if (ctl.phase != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          bits_left_nxt      = bl_load;
          ctl_nxt.is_read    = (item.cmd == CMD_READ);
          ctl_nxt.shift_word = (item.cmd == CMD_READ) ? '0 : item.write_word;
          ctl_nxt.phase      = PH_START;
        end
      end
      CMD_TICK: begin
        unique case (ctl.phase)
          PH_IDLE: begin
            ctl_nxt.phase = PH_IDLE;
          end
          PH_START: begin
            p[SEL_BIT]    = 1'b1;
            p[CLK_BIT]    = ~conv_mode;
            p[DAT_BIT]    = 1'b0;
            ctl_nxt.phase = PH_CSLOW;
          end
          PH_CSLOW: begin
            p[SEL_BIT] = 1'b0;
            if (ctl.is_read) begin
              if (bits_left == '0) begin
                done          = 1'b1;
                ctl_nxt.phase = PH_IDLE;
              end else begin
                ctl_nxt.phase = PH_RCLKDN;
              end
            end else begin
              ctl_nxt.phase = (bits_left == '0) ? PH_CSUP : PH_WCLKDN;
            end
          end
          PH_WCLKDN: begin
            p[CLK_BIT]    = 1'b0;
            ctl_nxt.phase = PH_WDATA;
          end
          PH_WDATA: begin
            p[DAT_BIT]    = tx_bit;
            ctl_nxt.phase = PH_WCLKUP;
          end
          PH_WCLKUP: begin
            p[CLK_BIT]    = 1'b1;
            bits_left_nxt = bl_dec;
            ctl_nxt.phase = (bl_dec == '0) ? PH_CSUP : PH_WCLKDN;
          end
          PH_CSUP: begin
            p[SEL_BIT]    = 1'b1;
            ctl_nxt.phase = PH_CLKDN;
          end
          PH_CLKDN: begin
            p[CLK_BIT]    = 1'b0;
            ctl_nxt.phase = PH_STOP;
          end
          PH_STOP: begin
            p[DAT_BIT]    = 1'b0;
            p[SEL_BIT]    = ~conv_mode;
            done          = 1'b1;
            ctl_nxt.phase = PH_IDLE;
          end
          PH_RCLKDN: begin
            p[CLK_BIT]         = 1'b0;
            ctl_nxt.shift_word = {ctl.shift_word[WORD_W-2:0], item.serial_in};
            ctl_nxt.phase      = PH_RCLKUP;
          end
          PH_RCLKUP: begin
            p[CLK_BIT]    = 1'b1;
            bits_left_nxt = bl_dec;
            if (bl_dec == '0) begin
              done          = 1'b1;
              ctl_nxt.phase = PH_IDLE;
            end else begin
              ctl_nxt.phase = PH_RCLKDN;
            end
          end
          default: begin
            ctl_nxt.phase = PH_IDLE;
          end
        endcase
      end
      CMD_NOP: begin
        ctl_nxt.phase = ctl.phase;
      end
      default: begin
        ctl_nxt.phase = ctl.phase;
      end
    endcase
    ctl_nxt.pins = p;
  end

  always_comb begin
    res.select_line   = p[SEL_BIT];
    res.clock_line    = p[CLK_BIT];
    res.data_out_line = p[DAT_BIT];
    res.busy_res      = (ctl_nxt.phase != PH_IDLE);
    res.read_word     = (done && ctl_nxt.is_read) ? ctl_nxt.shift_word : '0;
    res.done_res      = done;
    res.rejected      = rej;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/spims_checker.sv
// ----------------------------------------------------------------------------
// SPI master bit sequencer checker
// Port-level assertions on result items, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spims_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_select_line,
  input wire logic        out_clock_line,
  input wire logic        out_data_out_line,
  input wire logic        out_busy_res,
  input wire logic [31:0] out_read_word,
  input wire logic        out_done_res,
  input wire logic        out_rejected
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_word)
      && $stable(out_done_res) && $stable(out_select_line)
      && $stable(out_clock_line) && $stable(out_data_out_line))
    else $error("result item changed while stalled");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done item still reports busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res && !out_done_res)
    else $error("rejected start outside a running transaction");

  a_word_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_read_word == 32'd0)
    else $error("read word shown without done");

endmodule

bind spi_master_bit_sequencer spims_checker u_spims_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_select_line   (out_select_line),
  .out_clock_line    (out_clock_line),
  .out_data_out_line (out_data_out_line),
  .out_busy_res      (out_busy_res),
  .out_read_word     (out_read_word),
  .out_done_res      (out_done_res),
  .out_rejected      (out_rejected)
);

`default_nettype wire
